// File: rtl/b32c_pkg.sv
// Base32 stream codec: shared types and constants.
// Used by the front end, job queue, output sequencer and top level; no dependencies.
package b32c_pkg;

  localparam int unsigned ACC_W  = 12;
  localparam int unsigned HELD_W = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_3     = 3'd4;

  // default alphabet "ABCDEFGHIJKLMNOPQRSTUVWXYZ123456", entry 0 in the low byte
  localparam logic [63:0] ALPHA_RST_0 = 64'h4847_4645_4443_4241;
  localparam logic [63:0] ALPHA_RST_1 = 64'h504F_4E4D_4C4B_4A49;
  localparam logic [63:0] ALPHA_RST_2 = 64'h5857_5655_5453_5251;
  localparam logic [63:0] ALPHA_RST_3 = 64'h3635_3433_3231_5A59;

  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_ONE = 8'h31;
  localparam logic [4:0] DIGIT_BASE = 5'd26;

  // one queued job: the results caused by one item (cnt is 1 to 3)
  typedef struct packed {
    logic [2:0][7:0] data;
    logic            err;
    logic [1:0]      cnt;
  } job_t;

endpackage

// File: rtl/b32c_front.sv
// Base32 codec front end: config registers, bit accumulator, and per-item result build.
// Depends on b32c_pkg.
module b32c_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_data_in,
  input  logic                           in_end_of_message,
  input  logic                           cfg_we,
  input  logic [b32c_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [b32c_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           push,
  output b32c_pkg::job_t                 push_job
);
  import b32c_pkg::*;

  logic               mode_r;
  logic [3:0][63:0]   alpha_r;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [HELD_W-1:0]  held_r, held_nxt;
  logic               failed_r, failed_nxt;

  logic               accept;
  logic [255:0]       alpha_flat;
  logic [ACC_W-1:0]   enc_acc, dec_acc;
  logic [HELD_W-1:0]  enc_held, dec_held, enc_rem;
  logic [4:0]         g0, g1, gpad, dec_idx;
  logic               two_groups, pad_needed, char_ok;
  logic [ACC_W-1:0]   sh0, sh1, shpad, shdec;

  function automatic logic [7:0] alpha_char(input logic [255:0] tab, input logic [4:0] g);
    return tab[{g, 3'b000} +: 8];
  endfunction

  assign accept     = in_valid && in_ready;
  assign alpha_flat = alpha_r;

  always_comb begin
    // encode path: shift the byte in, then carve 5-bit groups from the top
    enc_acc    = {acc_r[3:0], in_data_in};
    enc_held   = held_r + 4'd8;
    two_groups = (enc_held >= 4'd10);
    sh0        = enc_acc >> (enc_held - 4'd5);
    g0         = sh0[4:0];
    sh1        = enc_acc >> (two_groups ? (enc_held - 4'd10) : 4'd0);
    g1         = sh1[4:0];
    enc_rem    = two_groups ? (enc_held - 4'd10) : (enc_held - 4'd5);
    pad_needed = in_end_of_message && (enc_rem != 4'd0);
    shpad      = enc_acc << (4'd5 - enc_rem);
    gpad       = shpad[4:0];

    // decode path
    char_ok = 1'b1;
    dec_idx = 5'd0;
    if (in_data_in inside {[8'h41:8'h5A]}) begin
      dec_idx = 5'(in_data_in - CHAR_A);
    end else if (in_data_in inside {[8'h31:8'h36]}) begin
      dec_idx = 5'(in_data_in - CHAR_ONE) + DIGIT_BASE;
    end else begin
      char_ok = 1'b0;
    end
    dec_acc  = {acc_r[6:0], dec_idx};
    dec_held = held_r + 4'd5;
    shdec    = dec_acc >> ((dec_held >= 4'd8) ? (dec_held - 4'd8) : 4'd0);
  end

  always_comb begin
    acc_nxt    = acc_r;
    held_nxt   = held_r;
    failed_nxt = failed_r;
    push_job   = '0;
    if (failed_r) begin
      // rest of a failed message is dropped silently
      if (in_end_of_message) failed_nxt = 1'b0;
    end else if (!mode_r) begin
      push_job.data[0] = alpha_char(alpha_flat, g0);
      push_job.data[1] = alpha_char(alpha_flat, two_groups ? g1 : gpad);
      push_job.data[2] = alpha_char(alpha_flat, gpad);
      push_job.cnt     = (two_groups ? 2'd2 : 2'd1) + {1'b0, pad_needed};
      acc_nxt  = enc_acc;
      held_nxt = enc_rem;
      if (in_end_of_message) begin
        acc_nxt  = '0;
        held_nxt = '0;
      end
    end else if (!char_ok) begin
      push_job.err = 1'b1;
      push_job.cnt = 2'd1;
      acc_nxt    = '0;
      held_nxt   = '0;
      failed_nxt = !in_end_of_message;
    end else begin
      acc_nxt  = dec_acc;
      held_nxt = dec_held;
      if (dec_held >= 4'd8) begin
        push_job.data[0] = shdec[7:0];
        push_job.cnt     = 2'd1;
        held_nxt         = dec_held - 4'd8;
      end
      if (in_end_of_message) begin
        acc_nxt  = '0;
        held_nxt = '0;
      end
    end
  end

  assign push = accept && (push_job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      alpha_r  <= {ALPHA_RST_3, ALPHA_RST_2, ALPHA_RST_1, ALPHA_RST_0};
      acc_r    <= '0;
      held_r   <= '0;
      failed_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECODE_MODE: begin
          mode_r   <= cfg_data[0];
          acc_r    <= '0;
          held_r   <= '0;
          failed_r <= 1'b0;
        end
        CFG_ALPHA_0: alpha_r[0] <= cfg_data;
        CFG_ALPHA_1: alpha_r[1] <= cfg_data;
        CFG_ALPHA_2: alpha_r[2] <= cfg_data;
        CFG_ALPHA_3: alpha_r[3] <= cfg_data;
        default: ;
      endcase
    end else if (accept) begin
      acc_r    <= acc_nxt;
      held_r   <= held_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// File: rtl/b32c_fifo.sv
// Base32 codec job queue between front end and output sequencer.
// Depends on b32c_pkg for the job type.
module b32c_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b32c_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output b32c_pkg::job_t q_job
);
  import b32c_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// File: rtl/b32c_back.sv
// Base32 codec back end: unrolls each queued job into single results on the output register.
// Depends on b32c_pkg for the job type.
module b32c_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  b32c_pkg::job_t q_job,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [7:0]     out_data_out,
  output logic           out_error_status,
  output logic           out_last_of_run
);
  import b32c_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] data_r;
  logic       err_r, last_r;
  logic       load, is_last;

  assign load    = q_valid && (!valid_r || !out_stall);
  assign is_last = (idx_r == (q_job.cnt - 2'd1));
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= q_job.data[idx_r];
      err_r  <= q_job.err;
      last_r <= is_last;
    end
  end

  assign out_valid        = valid_r;
  assign out_data_out     = data_r;
  assign out_error_status = err_r;
  assign out_last_of_run  = last_r;

endmodule

// File: rtl/base32_stream_codec_top.sv
// Base32 stream codec top level: front end, job queue and output sequencer.
// Depends on b32c_pkg, b32c_front, b32c_fifo and b32c_back.
//
// Usage:
//   cfg_we/cfg_index/cfg_data write the mode (index 0: 0 encode, 1 decode)
//   and the four alphabet words (indexes 1..4). Write only while idle; a mode
//   write also clears the message state.
//   Input items (in_data_in, in_end_of_message) are taken when in_valid is
//   high and in_stall low. Each item yields zero to three results on the
//   out_ channel, the last one flagged by out_last_of_run.
// Path: an item's results are written into the job queue, then loaded into the output register that drives out_valid.
// Throughput: the front end takes one item a cycle while the job queue has
//   room; the output register issues one result a cycle while out_stall is
//   low, so an item's output time grows with its results: encode 1 to 2 a byte
//   (2 or 3 on the last byte of a message, about 1.6 on average), decode 0 or 1 a character.
// Reset: synchronous; clears the queue, message state and the output valid,
//   restores the default alphabet and encode mode. in_stall is high in reset.
// A stalled output holds its result; the queue fills and in_stall rises.
module base32_stream_codec_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_in,
  input  logic                            in_end_of_message,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_data_out,
  output logic                            out_error_status,
  output logic                            out_last_of_run,
  input  logic                            cfg_we,
  input  logic [b32c_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [b32c_pkg::CFG_DATA_W-1:0] cfg_data
);
  import b32c_pkg::*;

  logic push, pop, full, q_valid;
  job_t push_job, q_job;

  assign in_stall = full || !rst_n;

  b32c_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (!in_stall),
    .in_data_in       (in_data_in),
    .in_end_of_message(in_end_of_message),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .push_job         (push_job)
  );

  b32c_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .full    (full),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  b32c_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (q_job),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_data_out    (out_data_out),
    .out_error_status(out_error_status),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: rtl/b32c_checker.sv
// Base32 codec port checker and its bind to the top level.
// Depends only on the top level's ports.
module b32c_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_out,
  input logic       out_error_status,
  input logic       out_last_of_run
);

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out)
      && $stable(out_error_status) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // an error result is alone and carries zero data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_status |-> out_data_out == 8'h00 && out_last_of_run)
    else $error("malformed error result");

  // output starting from empty needs an item taken earlier, passed through the job queue into the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an accepted item");

  // nothing is accepted while in reset
  assert property (@(posedge clk) !rst_n |-> in_stall)
    else $error("input open during reset");

endmodule

bind base32_stream_codec_top b32c_checker u_b32c_checker (.*);

// File: tb/sv/tb_base32_stream_codec_top.sv
// Self-checking testbench for base32_stream_codec_top: directed table, then random phases.
// Results are checked against an in-bench Base32 predictor.
// Depends on b32c_pkg and the codec RTL.
`timescale 1ns / 1ps

module tb_base32_stream_codec_top;
  import b32c_pkg::*;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  localparam logic [7:0] CHAR_Z   = "Z";
  localparam logic [7:0] CHAR_SIX = "6";
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;
  localparam int NDIR            = 25;
  localparam int NPHASE          = 8;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int SETTLE_CYCLES   = 4;
  localparam int IDLE_LIMIT      = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } coded_t;

  // one stimulus item; typed rows carry their own results
  typedef struct packed {
    logic            mode;
    logic [7:0]      data;
    logic            eom;
    logic            typed;
    logic [1:0]      n;
    logic [1:0][7:0] chars;
    logic            err;
  } stim_row_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_wr_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_in = 8'h00;
  logic                  in_end_of_message = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_data_out;
  logic                  out_error_status;
  logic                  out_last_of_run;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DECODE_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  base32_stream_codec_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_in       (in_data_in),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_out     (out_data_out),
    .out_error_status (out_error_status),
    .out_last_of_run  (out_last_of_run),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic        dec_mode = MODE_ENCODE;
  logic [63:0] alpha_w [4];
  logic [11:0] acc = '0;
  logic [3:0]  held = '0;
  logic        msg_failed = 1'b0;

  coded_t      base32_out_q [$];
  reg_wr_t     reg_plan [$];
  stim_row_t   dir_rows [NDIR];
  int          bad_count = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int unsigned cyc = 0;

  function automatic stim_row_t fixed_row(logic mode, logic [7:0] data, logic eom,
                                          logic [1:0] n, logic [7:0] c0, logic [7:0] c1,
                                          logic err);
    stim_row_t r;
    r.mode = mode; r.data = data; r.eom = eom; r.typed = 1'b1;
    r.n = n; r.chars = {c1, c0}; r.err = err;
    return r;
  endfunction

  function automatic stim_row_t free_row(logic mode, logic [7:0] data, logic eom);
    stim_row_t r;
    r = '0;
    r.mode = mode; r.data = data; r.eom = eom;
    return r;
  endfunction

  function automatic logic [7:0] alpha_lookup(logic [4:0] g);
    return alpha_w[g[4:3]][g[2:0]*8 +: 8];
  endfunction

  function automatic void clear_message();
    acc = '0;
    held = '0;
    msg_failed = 1'b0;
  endfunction

  // results caused by one item, with the state update
  task automatic base32_step(input logic [7:0] d, input logic eom,
                             output coded_t [2:0] r, output int n);
    logic [11:0] sh;
    logic [7:0]  diff;
    logic [4:0]  idx;
    logic        ok;
    n = 0;
    r = '0;
    if (msg_failed) begin
      if (eom) clear_message();
    end else if (dec_mode == MODE_ENCODE) begin
      acc = {acc[3:0], d};
      held = held + 4'd8;
      while (held >= 4'd5 && n < 2) begin
        sh = acc >> (held - 4'd5);
        r[n] = '{alpha_lookup(sh[4:0]), 1'b0, 1'b0};
        n++;
        held = held - 4'd5;
      end
      if (eom) begin
        if (held != 4'd0) begin
          sh = acc << (4'd5 - held);
          r[n] = '{alpha_lookup(sh[4:0]), 1'b0, 1'b0};
          n++;
        end
        clear_message();
      end
    end else begin
      ok = 1'b1;
      idx = '0;
      if (d >= CHAR_A && d <= CHAR_Z) begin
        diff = d - CHAR_A;
        idx = diff[4:0];
      end else if (d >= CHAR_ONE && d <= CHAR_SIX) begin
        diff = d - CHAR_ONE;
        idx = diff[4:0] + DIGIT_BASE;
      end else begin
        ok = 1'b0;
      end
      if (!ok) begin
        r[0] = '{8'h00, 1'b1, 1'b0};
        n = 1;
        acc = '0;
        held = '0;
        msg_failed = !eom;
      end else begin
        acc = {acc[6:0], idx};
        held = held + 4'd5;
        if (held >= 4'd8) begin
          sh = acc >> (held - 4'd8);
          r[0] = '{sh[7:0], 1'b0, 1'b0};
          n = 1;
          held = held - 4'd8;
        end
        if (eom) clear_message();
      end
    end
    if (n > 0) r[n-1].last = 1'b1;
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    bad_count++;
  endtask

  // drive one item, wait for it to be taken, then queue its results
  task automatic send_item(input stim_row_t s);
    coded_t [2:0] r;
    int           n;
    in_valid <= 1'b1;
    in_data_in <= s.data;
    in_end_of_message <= s.eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    base32_step(s.data, s.eom, r, n);
    if (s.typed) begin
      for (int k = 0; k < s.n; k++)
        base32_out_q.push_back('{s.chars[k], s.err, k == s.n - 1});
    end else begin
      for (int k = 0; k < n; k++) base32_out_q.push_back(r[k]);
    end
  endtask

  task automatic sender_pause();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // idle the sender until every queued result is out, plus pipeline slack
  task automatic drain_codec();
    in_valid <= 1'b0;
    while (base32_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_reg_plan();
    reg_wr_t w;
    while (reg_plan.size() != 0) begin
      w = reg_plan.pop_front();
      cfg_we <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      @(posedge clk);
      case (w.idx)
        CFG_DECODE_MODE: begin
          dec_mode = w.data[0];
          clear_message();
        end
        CFG_ALPHA_0, CFG_ALPHA_1, CFG_ALPHA_2, CFG_ALPHA_3:
          alpha_w[2'(w.idx - CFG_ALPHA_0)] = w.data;
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result checker
  always @(posedge clk) begin : chk_out
    coded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (base32_out_q.size() == 0) begin
        flag_mismatch("unexpected result", out_data_out, 8'h00);
      end else begin
        want = base32_out_q.pop_front();
        if (out_data_out !== want.data) flag_mismatch("data_out", out_data_out, want.data);
        if (out_error_status !== want.err)
          flag_mismatch("error_status", {7'd0, out_error_status}, {7'd0, want.err});
        if (out_last_of_run !== want.last)
          flag_mismatch("last_of_run", {7'd0, out_last_of_run}, {7'd0, want.last});
      end
    end
  end

  // receiver stall pattern: free, light random, heavy random, periodic
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc / 400) % 4)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (cyc % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_base32_stream_codec_top: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t   s;
    logic        cur_mode;
    logic        mode;
    logic [7:0]  ch;
    logic        eom;
    int          idx;
    int          counted;
    logic [63:0] wd;

    alpha_w[0] = ALPHA_RST_0;
    alpha_w[1] = ALPHA_RST_1;
    alpha_w[2] = ALPHA_RST_2;
    alpha_w[3] = ALPHA_RST_3;
    dir_rows = '{
      fixed_row(MODE_ENCODE, 8'h00, 1'b1, 2'd2, "A", "A", 1'b0),
      fixed_row(MODE_ENCODE, 8'hFF, 1'b1, 2'd2, "6", "3", 1'b0),
      // 0xA5 then 0x5A: second byte leaves one bit, so three results
      free_row(MODE_ENCODE, 8'hA5, 1'b0),
      free_row(MODE_ENCODE, 8'h5A, 1'b1),
      free_row(MODE_ENCODE, 8'h12, 1'b0),
      free_row(MODE_ENCODE, 8'h34, 1'b0),
      free_row(MODE_ENCODE, 8'h56, 1'b0),
      free_row(MODE_ENCODE, 8'h78, 1'b0),
      free_row(MODE_ENCODE, 8'h9A, 1'b1),
      fixed_row(MODE_DECODE, "A", 1'b0, 2'd0, 8'h00, 8'h00, 1'b0),
      fixed_row(MODE_DECODE, "A", 1'b1, 2'd1, 8'h00, 8'h00, 1'b0),
      fixed_row(MODE_DECODE, "6", 1'b0, 2'd0, 8'h00, 8'h00, 1'b0),
      fixed_row(MODE_DECODE, "6", 1'b1, 2'd1, 8'hFF, 8'h00, 1'b0),
      free_row(MODE_DECODE, "Z", 1'b0),
      free_row(MODE_DECODE, "1", 1'b0),
      // bad char mid-message: rest of the message is dropped
      fixed_row(MODE_DECODE, "7", 1'b0, 2'd1, 8'h00, 8'h00, 1'b1),
      fixed_row(MODE_DECODE, "B", 1'b0, 2'd0, 8'h00, 8'h00, 1'b0),
      fixed_row(MODE_DECODE, "C", 1'b1, 2'd0, 8'h00, 8'h00, 1'b0),
      fixed_row(MODE_DECODE, "@", 1'b1, 2'd1, 8'h00, 8'h00, 1'b1),
      fixed_row(MODE_DECODE, "[", 1'b1, 2'd1, 8'h00, 8'h00, 1'b1),
      fixed_row(MODE_DECODE, 8'h00, 1'b1, 2'd1, 8'h00, 8'h00, 1'b1),
      fixed_row(MODE_DECODE, 8'hFF, 1'b0, 2'd1, 8'h00, 8'h00, 1'b1),
      fixed_row(MODE_DECODE, "0", 1'b1, 2'd0, 8'h00, 8'h00, 1'b0),
      free_row(MODE_DECODE, "M", 1'b0),
      free_row(MODE_DECODE, "Y", 1'b1)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_mode = MODE_ENCODE;
    for (int i = 0; i < NDIR; i++) begin
      if (dir_rows[i].mode != cur_mode) begin
        drain_codec();
        reg_plan.push_back('{CFG_DECODE_MODE, {63'd0, dir_rows[i].mode}});
        apply_reg_plan();
        cur_mode = dir_rows[i].mode;
      end
      send_item(dir_rows[i]);
      sender_pause();
    end

    for (int p = 0; p < NPHASE; p++) begin
      drain_codec();
      case (p)
        0: begin
          reg_plan.push_back('{CFG_DECODE_MODE, 64'd0});
          reg_plan.push_back('{CFG_ALPHA_0, rand64()});
          reg_plan.push_back('{CFG_ALPHA_1, rand64()});
          reg_plan.push_back('{CFG_ALPHA_2, rand64()});
          reg_plan.push_back('{CFG_ALPHA_3, rand64()});
        end
        1: reg_plan.push_back('{CFG_DECODE_MODE, '1});
        2: begin
          // only bit 0 of the mode word counts
          reg_plan.push_back('{CFG_DECODE_MODE, 64'hFFFF_FFFF_FFFF_FFFE});
          reg_plan.push_back('{CFG_ALPHA_0, 64'd0});
          reg_plan.push_back('{CFG_ALPHA_1, '1});
          reg_plan.push_back('{CFG_IDX_W'($urandom_range(CFG_ALPHA_3 + 1, CFG_IDX_MAX)),
                               rand64()});
        end
        3: begin
          wd = rand64();
          wd[0] = MODE_DECODE;
          reg_plan.push_back('{CFG_DECODE_MODE, wd});
        end
        4: begin
          reg_plan.push_back('{CFG_DECODE_MODE, 64'd0});
          reg_plan.push_back('{CFG_ALPHA_0, ALPHA_RST_0});
          reg_plan.push_back('{CFG_ALPHA_1, ALPHA_RST_1});
          reg_plan.push_back('{CFG_ALPHA_2, ALPHA_RST_2});
          reg_plan.push_back('{CFG_ALPHA_3, ALPHA_RST_3});
        end
        default: begin
          // no mode write keeps any open message across the alphabet change
          if ($urandom_range(0, 1)) reg_plan.push_back('{CFG_DECODE_MODE, rand64()});
          if ($urandom_range(0, 1)) reg_plan.push_back('{CFG_ALPHA_0, rand64()});
          if ($urandom_range(0, 1)) reg_plan.push_back('{CFG_ALPHA_1, rand64()});
          if ($urandom_range(0, 1)) reg_plan.push_back('{CFG_ALPHA_2, rand64()});
          if ($urandom_range(0, 1)) reg_plan.push_back('{CFG_ALPHA_3, rand64()});
          if ($urandom_range(0, 3) == 0)
            reg_plan.push_back('{CFG_IDX_W'($urandom_range(CFG_ALPHA_3 + 1, CFG_IDX_MAX)),
                                 rand64()});
        end
      endcase
      apply_reg_plan();

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        mode = dec_mode;
        if (mode == MODE_ENCODE) begin
          ch = 8'($urandom_range(0, 255));
          eom = ($urandom_range(0, 5) == 0);
        end else begin
          // mostly legal characters, some noise
          if ($urandom_range(0, 99) < 88) begin
            idx = $urandom_range(0, 31);
            ch = 8'((idx < DIGIT_BASE) ? CHAR_A + idx : CHAR_ONE + (idx - DIGIT_BASE));
          end else begin
            ch = 8'($urandom_range(0, 255));
          end
          eom = ($urandom_range(0, 7) == 0);
        end
        counted++;
        s = free_row(mode, ch, eom);
        send_item(s);
        sender_pause();
      end
    end

    drain_codec();
    if (bad_count == 0)
      $display("tb_base32_stream_codec_top: PASS");
    else
      $display("tb_base32_stream_codec_top: FAIL");
    $finish;
  end

endmodule
